// ===== src/mfr_pkg.sv =====
// Shared types and constants for the message fragment reassembler.
// Used by the front stage, the queue, the back stage, the top level and the checker.
package mfr_pkg;

  // Fixed field widths.
  localparam int CAP_W  = 13;
  localparam int LEN_W  = 16;
  localparam int OP_W   = 4;
  localparam int CNT_W  = 4;
  localparam int DATA_W = 64;
  localparam int STAT_W = 2;
  localparam int KIND_W = 2;

  // The byte store is split into byte-wide banks so one chunk is one write per bank.
  localparam int NUM_BANKS  = 8;
  localparam int BANK_SEL_W = 3;

  // Queue between the front and back stages.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Frame opcodes.
  localparam logic [OP_W-1:0] OP_CONT   = 4'd0;
  localparam logic [OP_W-1:0] OP_TEXT   = 4'd1;
  localparam logic [OP_W-1:0] OP_BINARY = 4'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_INVALID  = 2'd0;
  localparam logic [STAT_W-1:0] ST_PARTIAL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_COMPLETE = 2'd2;
  localparam logic [STAT_W-1:0] ST_RESTART  = 2'd3;

  // One classified chunk as it travels from the front to the back.
  typedef struct packed {
    logic              restart;
    logic              bad;
    logic              start;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  offset;
    logic [OP_W-1:0]   opcode;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] data;
    logic [CAP_W-1:0]  cap;
  } mfr_item_t;

  // One result item.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KIND_W-1:0] mtype;
    logic [CAP_W-1:0]  mlen;
  } mfr_result_t;

endpackage

// ===== src/mfr_front.sv =====
// Front stage: holds the capacity register, accepts chunks and runs the
// stateless checks, then hands classified items to the queue. Uses mfr_pkg.
module mfr_front #(
  parameter int STORE_BYTES = 4096,
  parameter int CHUNK_BYTES = 8,
  parameter int LENGTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [mfr_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       restart,
  input  logic [mfr_pkg::LEN_W-1:0]  frame_len,
  input  logic [mfr_pkg::LEN_W-1:0]  chunk_offset,
  input  logic [mfr_pkg::OP_W-1:0]   frame_op,
  input  logic                       final_req,
  input  logic [mfr_pkg::CNT_W-1:0]  chunk_bytes,
  input  logic [mfr_pkg::DATA_W-1:0] chunk_data,
  input  logic                       q_ready,
  output logic                       q_valid,
  output mfr_pkg::mfr_item_t         q_item
);
  import mfr_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MASK =
    (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((32'd1 << LENGTH_BITS) - 32'd1);

  logic [CAP_W-1:0] buffer_capacity;
  logic [CAP_W-1:0] cap;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] offset;
  logic             bad;
  logic             valid;
  mfr_item_t        item;
  mfr_item_t        item_next;

  // Capacity register, to be written only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= CAP_W'(4096);
    end else if (cfg_write) begin
      buffer_capacity <= cfg_data;
    end
  end

  // Stateless checks: capacity, frame length, chunk size and frame bounds.
  always_comb begin
    cap    = (32'(buffer_capacity) > 32'(STORE_BYTES)) ? CAP_W'(STORE_BYTES) : buffer_capacity;
    length = frame_len & LEN_MASK;
    offset = chunk_offset & LEN_MASK;
    bad    = (cap == '0) || (length == '0) || (chunk_bytes > CNT_W'(CHUNK_BYTES)) ||
             (({1'b0, offset} + {{(LEN_W - CNT_W + 1){1'b0}}, chunk_bytes}) > {1'b0, length});
    item_next.restart = restart;
    item_next.bad     = bad;
    item_next.start   = (offset == '0);
    item_next.length  = length;
    item_next.offset  = offset;
    item_next.opcode  = frame_op;
    item_next.last    = final_req;
    item_next.count   = chunk_bytes;
    item_next.data    = chunk_data;
    item_next.cap     = cap;
  end

  assign in_ready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_item   = item;

  // One register stage in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (q_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== src/mfr_queue.sv =====
// Short FIFO of classified items between the front and back stages.
// Uses mfr_pkg for the item type and depth.
module mfr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mfr_pkg::mfr_item_t push_item,
  output logic               pop_valid,
  input  logic               pop,
  output mfr_pkg::mfr_item_t pop_item
);
  import mfr_pkg::*;

  mfr_item_t            entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (fill != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/mfr_back.sv =====
// Back stage: applies the ordering, opcode and capacity rules against the
// reassembly state, appends bytes to the banked store and registers the result.
// Uses mfr_pkg.
module mfr_back #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  mfr_pkg::mfr_item_t   q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mfr_pkg::mfr_result_t result
);
  import mfr_pkg::*;

  localparam int BANK_DEPTH = (STORE_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int IDX_W      =
    (BANK_AW + BANK_SEL_W > CAP_W + 1) ? BANK_AW + BANK_SEL_W : CAP_W + 1;

  // Reassembly state.
  logic              message_active, message_active_next;
  logic              cont_pending, cont_pending_next;
  logic [KIND_W-1:0] message_kind, message_kind_next;
  logic [CAP_W-1:0]  message_fill, message_fill_next;
  logic              fragment_active, fragment_active_next;
  logic [LEN_W-1:0]  fragment_length, fragment_length_next;
  logic [OP_W-1:0]   fragment_kind, fragment_kind_next;
  logic [LEN_W-1:0]  fragment_fill, fragment_fill_next;

  logic [STAT_W-1:0] status_next;
  logic              wr_en;
  logic [CAP_W-1:0]  fill_base;
  mfr_result_t       result_next;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // Rule checks and next state for the item at the head of the queue.
  always_comb begin
    logic             opened;
    logic             go;
    logic             overflow;
    logic [LEN_W-1:0] frag_base;
    logic [LEN_W-1:0] frag_sum;
    opened    = 1'b0;
    go        = 1'b0;
    overflow  = 1'b0;
    frag_base = fragment_fill;
    frag_sum  = '0;

    message_active_next  = message_active;
    cont_pending_next    = cont_pending;
    message_kind_next    = message_kind;
    message_fill_next    = message_fill;
    fragment_active_next = fragment_active;
    fragment_length_next = fragment_length;
    fragment_kind_next   = fragment_kind;
    fragment_fill_next   = fragment_fill;
    fill_base            = message_fill;
    status_next          = ST_INVALID;
    wr_en                = 1'b0;

    if (q_item.restart) begin
      message_active_next  = 1'b0;
      cont_pending_next    = 1'b0;
      message_kind_next    = '0;
      message_fill_next    = '0;
      fragment_active_next = 1'b0;
      fragment_length_next = '0;
      fragment_kind_next   = '0;
      fragment_fill_next   = '0;
      status_next          = ST_RESTART;
    end else if (!q_item.bad) begin
      // Frame start or continuation chunk of the open frame.
      if (q_item.start) begin
        if (!fragment_active) begin
          if (!message_active) begin
            if (q_item.opcode == OP_TEXT || q_item.opcode == OP_BINARY) begin
              message_active_next = 1'b1;
              message_kind_next   = q_item.opcode[KIND_W-1:0];
              fill_base           = '0;
              message_fill_next   = '0;
              opened              = 1'b1;
            end
          end else if (cont_pending && q_item.opcode == OP_CONT) begin
            opened = 1'b1;
          end
        end
        if (opened) begin
          cont_pending_next    = 1'b0;
          fragment_active_next = 1'b1;
          fragment_length_next = q_item.length;
          fragment_kind_next   = q_item.opcode;
          fragment_fill_next   = '0;
          frag_base            = '0;
          go                   = 1'b1;
        end
      end else if (fragment_active && fragment_length == q_item.length &&
                   fragment_kind == q_item.opcode && q_item.offset == fragment_fill) begin
        go = 1'b1;
      end

      // Room check: a lowered capacity below the fill leaves no room.
      overflow = (q_item.count != '0) &&
                 (({1'b0, fill_base} + {{(CAP_W - CNT_W + 1){1'b0}}, q_item.count}) >
                  {1'b0, q_item.cap});

      if (go && !overflow) begin
        wr_en             = 1'b1;
        message_fill_next = fill_base + {{(CAP_W - CNT_W){1'b0}}, q_item.count};
        frag_sum          = frag_base + {{(LEN_W - CNT_W){1'b0}}, q_item.count};
        if (frag_sum != q_item.length) begin
          fragment_fill_next = frag_sum;
          status_next        = ST_PARTIAL;
        end else begin
          fragment_active_next = 1'b0;
          fragment_fill_next   = '0;
          fragment_length_next = '0;
          fragment_kind_next   = '0;
          cont_pending_next    = !q_item.last;
          status_next          = q_item.last ? ST_COMPLETE : ST_PARTIAL;
        end
      end
    end

    result_next.status = status_next;
    result_next.mtype  = message_active_next ? message_kind_next : '0;
    result_next.mlen   = message_fill_next;
  end

  // State registers advance once per item taken from the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      message_active  <= 1'b0;
      cont_pending    <= 1'b0;
      message_kind    <= '0;
      message_fill    <= '0;
      fragment_active <= 1'b0;
      fragment_length <= '0;
      fragment_kind   <= '0;
      fragment_fill   <= '0;
    end else if (q_pop) begin
      message_active  <= message_active_next;
      cont_pending    <= cont_pending_next;
      message_kind    <= message_kind_next;
      message_fill    <= message_fill_next;
      fragment_active <= fragment_active_next;
      fragment_length <= fragment_length_next;
      fragment_kind   <= fragment_kind_next;
      fragment_fill   <= fragment_fill_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= result_next;
    end
  end

  // Byte store: consecutive bytes land in distinct banks, one write per bank.
  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    logic [7:0]            bank_mem [BANK_DEPTH];
    logic [BANK_SEL_W-1:0] lane;
    logic [IDX_W-1:0]      byte_idx;
    logic [BANK_AW-1:0]    bank_addr;
    logic [7:0]            bank_byte;
    logic                  bank_we;

    always_comb begin
      lane      = BANK_SEL_W'(g) - fill_base[BANK_SEL_W-1:0];
      byte_idx  = IDX_W'(fill_base) + IDX_W'(lane);
      bank_addr = byte_idx[BANK_AW+BANK_SEL_W-1:BANK_SEL_W];
      bank_byte = q_item.data[{lane, 3'b000} +: 8];
      bank_we   = q_pop && wr_en && ({1'b0, lane} < q_item.count);
    end

    always_ff @(posedge clk) begin
      if (bank_we) begin
        bank_mem[bank_addr] <= bank_byte;
      end
    end
  end

endmodule

// ===== src/message_fragment_reassembler.sv =====
// Top level of the message fragment reassembler.
// Instantiates mfr_front, mfr_queue and mfr_back; uses mfr_pkg.
//
// The block takes one chunk per clock cycle at a sustained rate while the
// output is not stalled. A result passes the front register, the two-entry
// queue and the result register before it is presented. With the output
// stalled the block holds four chunks before it lowers in_ready. The rate is
// set by the back stage, which applies all state rules and writes up to eight
// bytes into the eight-bank store, one byte per bank. Each chunk yields exactly
// one result. The capacity register resets to 4096 and must be written only
// while no chunk is in flight. There is no clearing pass; the byte store is
// only written, and this block has no read port for it.
module message_fragment_reassembler #(
  parameter int STORE_BYTES = 4096,
  parameter int CHUNK_BYTES = 8,
  parameter int LENGTH_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mfr_pkg::CAP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  input  logic [mfr_pkg::LEN_W-1:0]   frame_len,
  input  logic [mfr_pkg::LEN_W-1:0]   chunk_offset,
  input  logic [mfr_pkg::OP_W-1:0]    frame_op,
  input  logic                        final_req,
  input  logic [mfr_pkg::CNT_W-1:0]   chunk_bytes,
  input  logic [mfr_pkg::DATA_W-1:0]  chunk_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfr_pkg::STAT_W-1:0]  status,
  output logic [mfr_pkg::KIND_W-1:0]  message_type,
  output logic [mfr_pkg::CAP_W-1:0]   message_length
);
  import mfr_pkg::*;

  logic        f_valid;
  logic        f_ready;
  mfr_item_t   f_item;
  logic        q_valid;
  logic        q_pop;
  mfr_item_t   q_item;
  mfr_result_t result;

  // Front: configuration and stateless classification.
  mfr_front #(
    .STORE_BYTES (STORE_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .frame_len    (frame_len),
    .chunk_offset (chunk_offset),
    .frame_op     (frame_op),
    .final_req    (final_req),
    .chunk_bytes  (chunk_bytes),
    .chunk_data   (chunk_data),
    .q_ready      (f_ready),
    .q_valid      (f_valid),
    .q_item       (f_item)
  );

  // Queue between the two stages.
  mfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // Back: state rules, byte store and result register.
  mfr_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign status         = result.status;
  assign message_type   = result.mtype;
  assign message_length = result.mlen;

endmodule

// ===== src/mfr_checker.sv =====
// Port-level checks for the message fragment reassembler, bound to the top level.
// Uses mfr_pkg for the status codes.
module mfr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mfr_pkg::STAT_W-1:0] status,
  input logic [mfr_pkg::KIND_W-1:0] message_type,
  input logic [mfr_pkg::CAP_W-1:0]  message_length
);
  import mfr_pkg::*;

  // A stalled result holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(message_type) && $stable(message_length))
    else $error("result changed while stalled");

  // A restart reports an empty message.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RESTART |-> message_type == '0 && message_length == '0)
    else $error("restart result not cleared");

  // A completed message always has a text or binary type.
  a_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_COMPLETE |->
      message_type == KIND_W'(OP_TEXT) || message_type == KIND_W'(OP_BINARY))
    else $error("complete result without a message type");

  // A partial result belongs to an active message.
  a_partial: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_PARTIAL |-> message_type != '0)
    else $error("partial result without a message type");

endmodule

bind message_fragment_reassembler mfr_checker u_mfr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .message_type   (message_type),
  .message_length (message_length)
);

// ===== bench/message_fragment_reassembler_tb.sv =====
// Self-checking testbench for message_fragment_reassembler.
// Needs mfr_pkg and the reassembler RTL. It predicts each result in-line and
// compares every result transfer against the oldest prediction.
module message_fragment_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfr_pkg::*;

  localparam int unsigned STORE_MAX   = 4096;
  localparam int unsigned CHUNK_MAX   = 8;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 10;

  // One input chunk as the testbench sees it.
  typedef struct packed {
    logic        restart;
    logic [15:0] length;
    logic [15:0] offset;
    logic [3:0]  opcode;
    logic        last;
    logic [3:0]  count;
    logic [63:0] data;
  } chunk_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic [15:0] frame_len = '0;
  logic [15:0] chunk_offset = '0;
  logic [3:0]  frame_op = '0;
  logic        final_req = 1'b0;
  logic [3:0]  chunk_bytes = '0;
  logic [63:0] chunk_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [1:0]  message_type;
  logic [12:0] message_length;

  message_fragment_reassembler dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .restart        (restart),
    .frame_len      (frame_len),
    .chunk_offset   (chunk_offset),
    .frame_op       (frame_op),
    .final_req      (final_req),
    .chunk_bytes    (chunk_bytes),
    .chunk_data     (chunk_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .message_type   (message_type),
    .message_length (message_length)
  );

  always #5 clk = ~clk;

  // Chunks waiting to be offered, and results predicted but not yet seen.
  chunk_t      pending_chunks[$];
  mfr_result_t expected_results[$];
  chunk_t      cur;

  int unsigned chunks_queued = 0;
  int unsigned chunks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned n_partial = 0;
  int unsigned n_complete = 0;
  int unsigned n_invalid = 0;
  int unsigned n_restart = 0;
  int unsigned cycles = 0;
  int unsigned capacity_writes = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  // Shadow of the reassembly state and the capacity register.
  int unsigned model_cap = STORE_MAX;
  bit          msg_active = 1'b0;
  bit          await_cont = 1'b0;
  logic [1:0]  msg_kind = '0;
  int unsigned msg_fill = 0;
  bit          frag_active = 1'b0;
  int unsigned frag_len = 0;
  logic [3:0]  frag_kind = '0;
  int unsigned frag_fill = 0;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Advance the shadow state by one chunk and return the result it yields.
  function automatic mfr_result_t reassemble(chunk_t c);
    mfr_result_t r;
    int unsigned cap;
    int unsigned room;
    int unsigned len;
    int unsigned off;
    int unsigned cnt;
    logic [1:0]  st;
    bit          ok;
    len = c.length;
    off = c.offset;
    cnt = c.count;
    if (c.restart) begin
      msg_active = 1'b0;
      await_cont = 1'b0;
      msg_kind = '0;
      msg_fill = 0;
      frag_active = 1'b0;
      frag_len = 0;
      frag_kind = '0;
      frag_fill = 0;
      r.status = ST_RESTART;
      r.mtype = '0;
      r.mlen = '0;
      return r;
    end
    cap = (model_cap > STORE_MAX) ? STORE_MAX : model_cap;
    ok = !(cap == 0 || len == 0 || cnt > CHUNK_MAX || off + cnt > len);
    // A chunk at offset zero opens a frame; the opening sticks even if the
    // capacity check below throws the chunk away.
    if (ok && off == 0) begin
      if (frag_active) begin
        ok = 1'b0;
      end else if (!msg_active) begin
        if (c.opcode != OP_TEXT && c.opcode != OP_BINARY) begin
          ok = 1'b0;
        end else begin
          msg_active = 1'b1;
          msg_kind = c.opcode[1:0];
          msg_fill = 0;
        end
      end else if (!await_cont || c.opcode != OP_CONT) begin
        ok = 1'b0;
      end
      if (ok) begin
        await_cont = 1'b0;
        frag_active = 1'b1;
        frag_len = len;
        frag_kind = c.opcode;
        frag_fill = 0;
      end
    end else if (ok) begin
      if (!frag_active || frag_len != len || frag_kind != c.opcode || off != frag_fill) begin
        ok = 1'b0;
      end
    end
    if (ok) begin
      room = (msg_fill >= cap) ? 0 : cap - msg_fill;
      if (cnt > room) ok = 1'b0;
    end
    st = ST_INVALID;
    if (ok) begin
      msg_fill += cnt;
      frag_fill += cnt;
      st = ST_PARTIAL;
      if (frag_fill == frag_len) begin
        frag_active = 1'b0;
        frag_fill = 0;
        frag_len = 0;
        frag_kind = '0;
        if (!c.last) begin
          await_cont = 1'b1;
        end else begin
          await_cont = 1'b0;
          st = ST_COMPLETE;
        end
      end
    end
    r.status = st;
    r.mtype = msg_active ? msg_kind : 2'd0;
    r.mlen = 13'(msg_fill);
    return r;
  endfunction

  function automatic chunk_t make_chunk(logic rs, int unsigned len, int unsigned off,
                                        logic [3:0] op, logic fin, int unsigned cnt,
                                        logic [63:0] dat);
    chunk_t c;
    c.restart = rs;
    c.length = 16'(len);
    c.offset = 16'(off);
    c.opcode = op;
    c.last = fin;
    c.count = 4'(cnt);
    c.data = dat;
    return c;
  endfunction

  task automatic push_chunk(chunk_t c);
    pending_chunks.push_back(c);
    chunks_queued++;
  endtask

  task automatic push_restart();
    push_chunk(make_chunk(1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 15), rand64()));
  endtask

  // A random chunk; half of them have small lengths and offsets so they
  // sometimes land inside an open frame.
  function automatic chunk_t noise_chunk();
    chunk_t c;
    c.restart = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 1) == 0) begin
      c.length = 16'($urandom_range(0, 65535));
      c.offset = 16'($urandom_range(0, 65535));
    end else begin
      c.length = 16'($urandom_range(0, 16));
      c.offset = 16'($urandom_range(0, 16));
    end
    c.opcode = 4'($urandom_range(0, 15));
    c.last = 1'($urandom_range(0, 1));
    c.count = 4'($urandom_range(0, 15));
    c.data = rand64();
    return c;
  endfunction

  // One message of one to three frames, split into chunks in order. When
  // damaged is set, some chunks get one field broken.
  task automatic push_message(bit damaged);
    int unsigned frames;
    int unsigned flen;
    int unsigned off;
    int unsigned cnt;
    int unsigned left;
    logic [3:0]  op;
    bit          fin;
    chunk_t      c;
    frames = $urandom_range(1, 3);
    op = ($urandom_range(0, 1) != 0) ? OP_TEXT : OP_BINARY;
    for (int f = 0; f < frames; f++) begin
      flen = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      fin = (f == frames - 1);
      off = 0;
      do begin
        left = flen - off;
        cnt = ($urandom_range(0, 9) == 0) ? 0 :
              $urandom_range(1, (left > CHUNK_MAX) ? CHUNK_MAX : left);
        c = make_chunk(1'b0, flen, off, op,
                       (off + cnt == flen) ? fin : logic'($urandom_range(0, 1)),
                       cnt, rand64());
        if (damaged && $urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 4))
            0: c.offset = c.offset ^ (16'd1 << $urandom_range(0, 15));
            1: c.length = c.length + 16'd1;
            2: c.opcode = 4'($urandom_range(0, 15));
            3: c.count = 4'($urandom_range(9, 15));
            default: c.restart = 1'b1;
          endcase
        end
        push_chunk(c);
        off += cnt;
      end while (off < flen);
      op = OP_CONT;
    end
    if ($urandom_range(0, 9) != 0) push_restart();
  endtask

  task automatic run_random(int unsigned n);
    int unsigned stop;
    int unsigned pick;
    stop = chunks_queued + n;
    while (chunks_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) push_message(1'b0);
      else if (pick < 85) push_message(1'b1);
      else push_chunk(noise_chunk());
    end
  endtask

  // Wait until every chunk is sent and every result has come back.
  task automatic settle();
    @(negedge clk);
    while (pending_chunks.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Capacity register write; only called while the block is idle.
  task automatic set_capacity(int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= 13'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    model_cap = value;
    capacity_writes++;
    @(negedge clk);
  endtask

  // Sender: offer the next pending chunk, holding it until the transfer.
  always @(posedge clk) begin : sender
    bit fire;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        expected_results.push_back(reassemble(cur));
        chunks_sent++;
      end
      if (!in_valid || fire) begin
        if (pending_chunks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur = pending_chunks.pop_front();
          in_valid <= 1'b1;
          restart <= cur.restart;
          frame_len <= cur.length;
          chunk_offset <= cur.offset;
          frame_op <= cur.opcode;
          final_req <= cur.last;
          chunk_bytes <= cur.count;
          chunk_data <= cur.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down on its own.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls, and no transfers at all while the hold-off runs.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && !hold_req && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker: each result transfer against the oldest prediction.
  always @(posedge clk) begin : result_check
    mfr_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      case (status)
        ST_PARTIAL:  n_partial++;
        ST_COMPLETE: n_complete++;
        ST_RESTART:  n_restart++;
        default:     n_invalid++;
      endcase
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result %0d: status %0d type %0d length %0d", results_seen,
                   status, message_type, message_length);
        end
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || message_type !== want.mtype ||
            message_length !== want.mlen) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result %0d: expected status %0d type %0d length %0d, got %0d %0d %0d",
                     results_seen, want.status, want.mtype, want.mlen,
                     status, message_type, message_length);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed checks at the reset capacity, no idling.
    push_chunk(make_chunk(1'b1, 0, 0, OP_CONT, 1'b0, 0, '0));
    push_chunk(make_chunk(1'b0, 0, 0, OP_TEXT, 1'b0, 0, rand64()));
    push_chunk(make_chunk(1'b0, 8, 0, 4'd5, 1'b0, 4, rand64()));
    push_chunk(make_chunk(1'b0, 8, 0, OP_CONT, 1'b0, 4, rand64()));
    push_chunk(make_chunk(1'b0, 16, 0, OP_TEXT, 1'b0, 9, rand64()));
    push_chunk(make_chunk(1'b0, 4, 0, OP_TEXT, 1'b0, 8, rand64()));
    push_chunk(make_chunk(1'b0, 12, 0, OP_TEXT, 1'b0, 8, rand64()));
    push_chunk(make_chunk(1'b0, 12, 0, OP_TEXT, 1'b0, 4, rand64()));
    push_chunk(make_chunk(1'b0, 13, 8, OP_TEXT, 1'b0, 4, rand64()));
    push_chunk(make_chunk(1'b0, 12, 7, OP_TEXT, 1'b0, 4, rand64()));
    push_chunk(make_chunk(1'b0, 12, 8, OP_BINARY, 1'b0, 4, rand64()));
    push_chunk(make_chunk(1'b0, 12, 8, OP_TEXT, 1'b0, 4, rand64()));
    push_chunk(make_chunk(1'b0, 5, 0, OP_TEXT, 1'b0, 5, rand64()));
    push_chunk(make_chunk(1'b0, 3, 0, OP_CONT, 1'b1, 3, rand64()));
    push_chunk(make_chunk(1'b0, 3, 0, OP_BINARY, 1'b1, 3, rand64()));
    push_chunk(make_chunk(1'b1, 0, 0, OP_CONT, 1'b0, 0, '0));
    push_chunk(make_chunk(1'b0, 65535, 0, OP_BINARY, 1'b1, 8, '1));
    push_chunk(make_chunk(1'b0, 65535, 65530, OP_BINARY, 1'b1, 5, '1));
    settle();

    // Small capacity: a chunk that overflows is dropped, the frame stays open.
    set_capacity(16);
    push_chunk(make_chunk(1'b1, 0, 0, OP_CONT, 1'b0, 0, '0));
    push_chunk(make_chunk(1'b0, 20, 0, OP_TEXT, 1'b0, 8, rand64()));
    push_chunk(make_chunk(1'b0, 20, 8, OP_TEXT, 1'b0, 8, rand64()));
    push_chunk(make_chunk(1'b0, 20, 16, OP_TEXT, 1'b0, 4, rand64()));
    settle();

    // Capacity dropped under the fill: only empty chunks get through, and a
    // frame opened by an overflowing chunk stays open.
    set_capacity(8);
    push_chunk(make_chunk(1'b0, 20, 16, OP_TEXT, 1'b0, 0, rand64()));
    push_chunk(make_chunk(1'b0, 20, 16, OP_TEXT, 1'b0, 1, rand64()));
    push_chunk(make_chunk(1'b1, 0, 0, OP_CONT, 1'b0, 0, '0));
    push_chunk(make_chunk(1'b0, 6, 0, OP_TEXT, 1'b0, 6, rand64()));
    push_chunk(make_chunk(1'b0, 4, 0, OP_CONT, 1'b1, 4, rand64()));
    push_chunk(make_chunk(1'b0, 4, 0, OP_CONT, 1'b1, 2, rand64()));
    settle();

    // Random traffic across capacity settings and idle patterns.
    set_capacity(STORE_MAX);
    push_restart();
    run_random(400);
    settle();

    set_capacity(8191);
    send_idle_pct = 51;
    run_random(350);
    settle();

    set_capacity(100);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    run_random(350);
    settle();

    set_capacity(0);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    run_random(100);
    settle();

    set_capacity(1);
    run_random(100);
    settle();

    // Back-pressure: the receiver holds off while the sender keeps offering.
    set_capacity(STORE_MAX);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_restart();
    run_random(300);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    settle();

    set_capacity(2000);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    push_restart();
    run_random(400);

    // Drain, then give any stray result time to show up.
    waited = 0;
    @(negedge clk);
    while ((pending_chunks.size() != 0 || in_valid || expected_results.size() != 0) &&
           waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(negedge clk);
    if (pending_chunks.size() != 0 || in_valid) begin
      $display("%0d chunks were never transferred", pending_chunks.size() + int'(in_valid));
      mismatches += pending_chunks.size() + int'(in_valid);
    end
    if (expected_results.size() != 0) begin
      $display("%0d predicted results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("%0d chunks transferred under %0d capacity writes, with a long receiver hold-off",
             chunks_sent, capacity_writes);
    $display("results: %0d partial, %0d complete, %0d rejected, %0d restarts, %0d mismatches",
             n_partial, n_complete, n_invalid, n_restart, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mfr_pkg.sv
src/mfr_front.sv
src/mfr_queue.sv
src/mfr_back.sv
src/message_fragment_reassembler.sv
src/mfr_checker.sv
bench/message_fragment_reassembler_tb.sv
